FILE: hdl/deu_pkg.sv
package deu_pkg;

   localparam int WORD_W     = 32;
   localparam int SAMPLE_W   = 10;
   localparam int LANES      = 3;
   localparam int LANE_W     = 2;
   localparam int CNT_W      = 12;
   localparam int THIRD_W    = 11;
   localparam int SIZE_W     = 28;
   localparam int EVC_W      = 24;
   localparam int TS_W       = 32;
   localparam int CH_W       = 3;
   localparam int MASK_W     = 8;
   localparam int NCH_W      = 4;
   localparam int PROD_W     = 15;
   localparam int RSP_DATA_W = 88;
   localparam int RSP_PAD_W  = RSP_DATA_W - (CH_W + CNT_W + SAMPLE_W + EVC_W + TS_W);

   localparam logic [3:0]        SIGNATURE   = 4'hA;
   localparam logic              KIND_SAMPLE = 1'b0;
   localparam logic              KIND_ERROR  = 1'b1;
   localparam logic [SIZE_W-1:0] HEADER_LEN  = 28'd4;

   typedef enum logic [2:0] {
      ST_DROP,
      ST_MASK,
      ST_COUNT,
      ST_TIME,
      ST_DATA
   } state_type;

   typedef struct packed {
      logic                kind;
      logic                last;
      logic [CH_W-1:0]     channel;
      logic [CNT_W-1:0]    index;
      logic [SAMPLE_W-1:0] value;
      logic [EVC_W-1:0]    event_count;
      logic [TS_W-1:0]     timestamp;
   } res_type;

   typedef struct packed {
      logic             emit_err;
      logic             emit_data;
      logic             done;
      logic [CH_W-1:0]  channel;
      logic [CNT_W-1:0] counter;
      logic [EVC_W-1:0] event_count;
      logic [TS_W-1:0]  timestamp;
   } ctl_type;

   function automatic logic [NCH_W-1:0] popcount8(input logic [MASK_W-1:0] m);
      logic [NCH_W-1:0] n;
      n = '0;
      for (int c = 0; c < MASK_W; c++) begin
         n = n + NCH_W'(m[c]);
      end
      return n;
   endfunction

   // msb set when no channel at or above from is enabled
   function automatic logic [CH_W:0] first_set(input logic [MASK_W-1:0] m,
                                               input logic [CH_W:0] from);
      logic [CH_W:0] r;
      r = {1'b1, {CH_W{1'b0}}};
      for (int c = MASK_W - 1; c >= 0; c--) begin
         if (m[c] && (CH_W+1)'(c) >= from) begin
            r = (CH_W+1)'(c);
         end
      end
      return r;
   endfunction

endpackage

FILE: hdl/deu_lane.sv
module deu_lane (
   input  logic [deu_pkg::WORD_W-1:0] word,
   input  logic [deu_pkg::LANE_W-1:0] lane,
   input  deu_pkg::ctl_type           ctl,
   output deu_pkg::res_type           res
);
   import deu_pkg::*;

   logic [WORD_W-1:0] shifted;

   assign shifted = word >> (SAMPLE_W * int'(lane));

   always_comb begin
      res.kind        = KIND_SAMPLE;
      res.last        = ctl.done && (lane == LANE_W'(LANES - 1));
      res.channel     = ctl.channel;
      res.index       = ctl.counter + CNT_W'(lane);
      res.value       = shifted[SAMPLE_W-1:0];
      res.event_count = ctl.event_count;
      res.timestamp   = ctl.timestamp;
   end

endmodule

FILE: hdl/deu_parse.sv
module deu_parse (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [deu_pkg::WORD_W-1:0]  word,
   input  logic                        first,
   input  logic [deu_pkg::MASK_W-1:0]  ch_bits,
   input  logic [deu_pkg::CNT_W-1:0]   spc,
   input  logic [deu_pkg::THIRD_W-1:0] spc_third,
   input  logic                        spc_good,
   output deu_pkg::ctl_type            ctl
);
   import deu_pkg::*;

   state_type          state_ff, state_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [CH_W-1:0]    chan_ff, chan_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [EVC_W-1:0]   evc_ff, evc_in;
   logic [TS_W-1:0]    ts_ff, ts_in;

   logic               sig_ok;
   logic [MASK_W-1:0]  mask_w;
   logic [NCH_W-1:0]   nch;
   logic [SIZE_W-1:0]  span;
   logic [PROD_W-1:0]  lo;
   logic [PROD_W-1:0]  hi;
   logic               size_ok;
   logic               wrap;
   logic [CH_W:0]      nxt;
   logic [CH_W:0]      head;
   logic               done;

   assign sig_ok  = (word[WORD_W-1 -: 4] == SIGNATURE);
   assign mask_w  = word[MASK_W-1:0] & ch_bits;
   assign nch     = popcount8(mask_w);
   assign span    = size_ff - HEADER_LEN;
   assign lo      = PROD_W'(spc_third) * PROD_W'(nch);
   assign hi      = lo + PROD_W'(nch);
   assign size_ok = (nch != '0) && (size_ff >= HEADER_LEN) && spc_good
                    && (span >= SIZE_W'(lo)) && (span < SIZE_W'(hi));

   assign wrap = ((CNT_W+1)'(cnt_ff) + (CNT_W+1)'(LANES)) >= (CNT_W+1)'(spc);
   assign nxt  = first_set(mask_ff, (CH_W+1)'(chan_ff) + (CH_W+1)'(1));
   assign head = first_set(mask_ff, '0);
   assign done = wrap && nxt[CH_W];

   // next state
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         if (first) begin
            state_in = sig_ok ? ST_MASK : ST_DROP;
         end else begin
            case (state_ff)
               ST_MASK:  state_in = size_ok ? ST_COUNT : ST_DROP;
               ST_COUNT: state_in = ST_TIME;
               ST_TIME:  state_in = ST_DATA;
               ST_DATA:  state_in = done ? ST_DROP : ST_DATA;
               default:  state_in = ST_DROP;
            endcase
         end
      end
   end

   // outputs and event registers
   always_comb begin
      mask_in         = mask_ff;
      size_in         = size_ff;
      chan_in         = chan_ff;
      cnt_in          = cnt_ff;
      evc_in          = evc_ff;
      ts_in           = ts_ff;
      ctl.emit_err    = 1'b0;
      ctl.emit_data   = 1'b0;
      ctl.done        = done;
      ctl.channel     = chan_ff;
      ctl.counter     = cnt_ff;
      ctl.event_count = evc_ff;
      ctl.timestamp   = ts_ff;
      if (accept) begin
         if (first) begin
            if (sig_ok) begin
               size_in = word[SIZE_W-1:0];
            end else begin
               ctl.emit_err = 1'b1;
            end
         end else begin
            case (state_ff)
               ST_MASK: begin
                  mask_in      = mask_w;
                  ctl.emit_err = !size_ok;
               end
               ST_COUNT: begin
                  evc_in = word[EVC_W-1:0];
               end
               ST_TIME: begin
                  ts_in   = word;
                  chan_in = head[CH_W-1:0];
                  cnt_in  = '0;
               end
               ST_DATA: begin
                  ctl.emit_data = 1'b1;
                  if (wrap && !done) begin
                     chan_in = nxt[CH_W-1:0];
                     cnt_in  = '0;
                  end else if (!wrap) begin
                     cnt_in = cnt_ff + CNT_W'(LANES);
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_DROP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      size_ff <= size_in;
      chan_ff <= chan_in;
      cnt_ff  <= cnt_in;
      evc_ff  <= evc_in;
      ts_ff   <= ts_in;
   end

endmodule

FILE: hdl/deu_merge.sv
module deu_merge (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  logic             load_err,
   input  deu_pkg::res_type lane_res [deu_pkg::LANES],
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output deu_pkg::res_type rsp_res,
   output logic             take_ready
);
   import deu_pkg::*;

   res_type           res_ff [LANES];
   res_type           res_in [LANES];
   logic [LANE_W-1:0] left_ff, left_in;
   logic [LANE_W-1:0] ptr_ff, ptr_in;
   logic              pop;
   res_type           err_res;

   assign rsp_valid  = (left_ff != '0);
   assign rsp_res    = res_ff[ptr_ff];
   assign pop        = rsp_valid && rsp_ready;
   assign take_ready = (left_ff == '0) || (left_ff == LANE_W'(1) && rsp_ready);

   always_comb begin
      err_res      = '0;
      err_res.kind = KIND_ERROR;
      err_res.last = 1'b1;
   end

   always_comb begin
      res_in  = res_ff;
      left_in = left_ff;
      ptr_in  = ptr_ff;
      if (pop) begin
         left_in = left_ff - LANE_W'(1);
         ptr_in  = ptr_ff + LANE_W'(1);
      end
      if (load) begin
         ptr_in = '0;
         if (load_err) begin
            res_in[0] = err_res;
            left_in   = LANE_W'(1);
         end else begin
            res_in  = lane_res;
            left_in = LANE_W'(LANES);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         ptr_ff  <= '0;
      end else begin
         left_ff <= left_in;
         ptr_ff  <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

endmodule

FILE: hdl/digitizer_event_unpacker_unit.sv
// Digitizer event unpacker. Takes a digitizer event one 32-bit word at a time on req_;
// req_tuser marks header word 0 (signature 0xA in bits 31..28, event size in bits
// 27..0), followed by the channel mask, the event count and the timestamp. Each data
// word is split by three sample lanes into three 10-bit samples, tagged with channel,
// index, event count and timestamp, and sent as three rsp_ words, one per cycle
// while rsp_tready is high; the final sample of an event has rsp_tlast set. A bad
// signature, an empty mask or a size that does not match csr_wdata samples per
// channel gives one error word (rsp_tuser high, rsp_tlast high, payload zero), and
// words are then dropped until the next header word 0. A data word fills the
// three-entry result buffer, which drains one word per cycle while rsp_tready is
// high; a word is taken whenever that buffer is empty or sending its final entry.
module digitizer_event_unpacker_unit #(
   parameter int CHANNEL_COUNT = 8,
   parameter int MAX_SAMPLES   = 4095
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [deu_pkg::WORD_W-1:0]      req_tdata,  // word
   input  logic                            req_tuser,  // first_word
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // channel, sample_index, sample_value, event_count, timestamp, zero pad
   output logic [deu_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tuser,  // kind
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [deu_pkg::CNT_W-1:0]       csr_wdata
);
   import deu_pkg::*;

   localparam int MAX_BITS = $clog2(MAX_SAMPLES + 1);
   localparam int CMP_W    = (MAX_BITS > CNT_W) ? MAX_BITS : CNT_W;
   localparam logic [MASK_W-1:0] CH_BITS =
      MASK_W'(((MASK_W+1)'(1) << CHANNEL_COUNT) - (MASK_W+1)'(1));

   logic [CNT_W-1:0]   spc_ff, spc_in;
   logic [THIRD_W-1:0] third_ff, third_in;
   logic               good_ff, good_in;
   logic [CNT_W+THIRD_W+1:0] recip;
   logic [CNT_W-1:0]   rem;

   logic    req_accept;
   ctl_type ctl;
   res_type lane_res [LANES];
   res_type rsp_res;

   // samples per channel over three by reciprocal multiply
   assign recip    = (CNT_W+THIRD_W+2)'(csr_wdata) * (CNT_W+THIRD_W+2)'(2731);
   assign third_in = recip[CNT_W+THIRD_W -: THIRD_W];
   assign rem      = csr_wdata - CNT_W'(third_in * CNT_W'(LANES));
   assign good_in  = (rem == '0) && (csr_wdata != '0)
                     && (CMP_W'(csr_wdata) <= CMP_W'(MAX_SAMPLES));
   assign spc_in   = csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         spc_ff   <= CNT_W'(LANES);
         third_ff <= THIRD_W'(1);
         good_ff  <= 1'b1;
      end else if (csr_we) begin
         spc_ff   <= spc_in;
         third_ff <= third_in;
         good_ff  <= good_in;
      end
   end

   assign req_accept = req_tvalid && req_tready;

   deu_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .word      (req_tdata),
      .first     (req_tuser),
      .ch_bits   (CH_BITS),
      .spc       (spc_ff),
      .spc_third (third_ff),
      .spc_good  (good_ff),
      .ctl       (ctl)
   );

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      deu_lane u_lane (
         .word (req_tdata),
         .lane (LANE_W'(i)),
         .ctl  (ctl),
         .res  (lane_res[i])
      );
   end

   deu_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept && (ctl.emit_err || ctl.emit_data)),
      .load_err   (ctl.emit_err),
      .lane_res   (lane_res),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_res    (rsp_res),
      .take_ready (req_tready)
   );

   assign rsp_tdata = {RSP_PAD_W'(0), rsp_res.timestamp, rsp_res.event_count,
                       rsp_res.value, rsp_res.index, rsp_res.channel};
   assign rsp_tuser = rsp_res.kind;
   assign rsp_tlast = rsp_res.last;

   a_err_word: assert property (@(posedge clock) disable iff (reset)
      req_accept && ctl.emit_err |=> rsp_tvalid && rsp_tuser == KIND_ERROR && rsp_tlast)
      else $error("error word not presented after format error");

   a_data_word: assert property (@(posedge clock) disable iff (reset)
      req_accept && ctl.emit_data |=>
         rsp_tvalid && rsp_tuser == KIND_SAMPLE && rsp_res.index == $past(ctl.counter))
      else $error("first sample of data word missing or misindexed");

   a_err_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_ERROR |-> rsp_tdata == '0 && rsp_tlast)
      else $error("error word carries payload");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_accept && ctl.emit_data |-> !rsp_tvalid || (rsp_tready && req_tready))
      else $error("data word loaded over pending results");

endmodule

FILE: dv/digitizer_event_unpacker_unit_tb.sv
module digitizer_event_unpacker_unit_tb;
   import deu_pkg::*;

   localparam int CHANNELS      = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int IDX_LSB       = CH_W;
   localparam int VAL_LSB       = IDX_LSB + CNT_W;
   localparam int EVC_LSB       = VAL_LSB + SAMPLE_W;
   localparam int TS_LSB        = EVC_LSB + EVC_W;
   localparam int PAD_LSB       = TS_LSB + TS_W;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [WORD_W-1:0]     req_tdata;   // word
   logic                  req_tuser;   // first_word
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // channel, sample_index, sample_value, event_count, timestamp, zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;   // kind
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [CNT_W-1:0]      csr_wdata;

   // unpacker state as seen by the scoreboard
   state_type         phase       = ST_DROP;
   logic [CNT_W-1:0]  samples_cfg = 12'd3;
   logic [MASK_W-1:0] chan_mask   = '0;
   logic [SIZE_W-1:0] size_words  = '0;
   logic [CH_W-1:0]   chan        = '0;
   logic [CNT_W-1:0]  cnt         = '0;
   logic [EVC_W-1:0]  evc         = '0;
   logic [TS_W-1:0]   ts          = '0;

   res_type sample_fifo[$];
   res_type oldest;
   int      mismatches   = 0;
   int      words_sent   = 0;
   int      quiet_cycles = 0;
   logic    steady       = 1'b0;
   logic    hold_request = 1'b0;

   digitizer_event_unpacker_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic int count_channels(input logic [MASK_W-1:0] m);
      int n;
      n = 0;
      for (int c = 0; c < CHANNELS; c++) begin
         n += m[c];
      end
      return n;
   endfunction

   function automatic int next_enabled(input logic [MASK_W-1:0] m, input int from);
      for (int c = from; c < CHANNELS; c++) begin
         if (m[c]) begin
            return c;
         end
      end
      return CHANNELS;
   endfunction

   function automatic void push_error();
      res_type r;
      r = '0;
      r.kind = KIND_ERROR;
      r.last = 1'b1;
      sample_fifo.push_back(r);
      phase = ST_DROP;
   endfunction

   function automatic void unpack_word(input logic [WORD_W-1:0] w, input logic first);
      res_type r;
      int      chans;
      int      nxt;
      logic    done;
      longint  per;
      if (first) begin
         if (w[31:28] != SIGNATURE) begin
            push_error();
         end else begin
            size_words = w[SIZE_W-1:0];
            phase = ST_MASK;
         end
      end else begin
         case (phase)
            ST_MASK: begin
               chan_mask = w[MASK_W-1:0];
               chans = count_channels(chan_mask);
               if (chans == 0 || size_words < 4) begin
                  push_error();
               end else begin
                  per = (longint'(size_words) - 4) / chans * 3;
                  if (samples_cfg == 0 || per != longint'(samples_cfg)) begin
                     push_error();
                  end else begin
                     phase = ST_COUNT;
                  end
               end
            end
            ST_COUNT: begin
               evc = w[EVC_W-1:0];
               phase = ST_TIME;
            end
            ST_TIME: begin
               ts = w;
               chan = CH_W'(next_enabled(chan_mask, 0));
               cnt = '0;
               phase = ST_DATA;
            end
            ST_DATA: begin
               if (int'(cnt) + 3 >= int'(samples_cfg)) begin
                  nxt = next_enabled(chan_mask, int'(chan) + 1);
                  done = (nxt >= CHANNELS);
               end else begin
                  nxt = int'(chan);
                  done = 1'b0;
               end
               for (int k = 0; k < LANES; k++) begin
                  r.kind = KIND_SAMPLE;
                  r.last = done && (k == LANES - 1);
                  r.channel = chan;
                  r.index = cnt + CNT_W'(k);
                  r.value = w[SAMPLE_W*k +: SAMPLE_W];
                  r.event_count = evc;
                  r.timestamp = ts;
                  sample_fifo.push_back(r);
               end
               if (done) begin
                  phase = ST_DROP;
               end else if (nxt != int'(chan)) begin
                  chan = CH_W'(nxt);
                  cnt = '0;
               end else begin
                  cnt = cnt + CNT_W'(3);
               end
            end
            default: begin
            end
         endcase
      end
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (sample_fifo.size() == 0) begin
            $display("%0t: result word mismatch, expected none, actual kind %b last %b data %h",
                     $time, rsp_tuser, rsp_tlast, rsp_tdata);
            mismatches++;
         end else begin
            oldest = sample_fifo.pop_front();
            check_field("kind", oldest.kind, rsp_tuser);
            check_field("last_of_event", oldest.last, rsp_tlast);
            check_field("channel", oldest.channel, rsp_tdata[CH_W-1:0]);
            check_field("sample_index", oldest.index, rsp_tdata[IDX_LSB +: CNT_W]);
            check_field("sample_value", oldest.value, rsp_tdata[VAL_LSB +: SAMPLE_W]);
            check_field("event_count", oldest.event_count, rsp_tdata[EVC_LSB +: EVC_W]);
            check_field("timestamp", oldest.timestamp, rsp_tdata[TS_LSB +: TS_W]);
            check_field("pad", '0, rsp_tdata[PAD_LSB +: RSP_PAD_W]);
         end
      end
      if (!reset && req_tvalid && req_tready === 1'b1) begin
         unpack_word(req_tdata, req_tuser);
      end
      if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
      end
      $display("== FAIL ==");
      $finish;
   end

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) begin
         return 0;
      end
      if (r < 88) begin
         return $urandom_range(1, 3);
      end
      if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // result side stalls
   initial begin
      int   stall;
      logic held;
      held       = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            stall = idle_length();
            if (stall == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               repeat (stall - 1) @(negedge clock);
            end
         end
      end
   end

   task automatic send_word(input logic [WORD_W-1:0] w, input logic first);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tuser  <= first;
      do @(posedge clock); while (req_tready !== 1'b1);
      words_sent++;
   endtask

   task automatic send_event_words(input logic [WORD_W-1:0] head,
                                   input logic [MASK_W-1:0] mask, input int count);
      logic [WORD_W-1:0] w;
      send_word(head, 1'b1);
      for (int i = 1; i < count; i++) begin
         w = $urandom;
         if (i == 1) begin
            w[MASK_W-1:0] = mask;
         end
         send_word(w, 1'b0);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sample_fifo.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_samples(input logic [CNT_W-1:0] v);
      // bad signature parks the block in the drop state first
      send_word({~SIGNATURE, 28'd0}, 1'b1);
      drain();
      csr_wdata <= v;
      csr_we    <= 1'b1;
      samples_cfg = v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic test_idle_words();
      send_word($urandom, 1'b0);
      send_word(32'hA000_0005, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      drain();
   endtask

   task automatic test_directed_events();
      send_word(32'h0000_0000, 1'b1);
      // one channel, all-ones header fields and samples
      send_word(32'hA000_0005, 1'b1);
      send_word(32'hFFFF_FF01, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      // three channels with two surplus words
      send_word(32'hA000_0009, 1'b1);
      send_word(32'h0000_0007, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h3FF0_03FF, 1'b0);
      send_word(32'h2AAA_AAAA, 1'b0);
      send_word(32'h1555_5555, 1'b0);
      send_word(32'hC000_0000, 1'b0);
      // size mismatch at the largest size
      send_word(32'hAFFF_FFFF, 1'b1);
      send_word(32'h0000_0080, 1'b0);
      // size below the header length
      send_word(32'hA000_0003, 1'b1);
      send_word(32'h0000_0001, 1'b0);
      // empty mask
      send_word(32'hA000_000C, 1'b1);
      send_word(32'hFFFF_FF00, 1'b0);
      // new header before the end of an event
      send_word(32'hA000_0005, 1'b1);
      send_word(32'h0000_0080, 1'b0);
      send_word(32'h1234_5678, 1'b0);
      send_word(32'hF000_0005, 1'b1);
      drain();
   endtask

   task automatic test_odd_settings();
      set_samples(12'd4);
      send_event_words({SIGNATURE, 28'd5}, 8'h01, 2);
      send_event_words({SIGNATURE, 28'd8}, 8'h01, 2);
      set_samples(12'd6);
      send_event_words({SIGNATURE, 28'd8}, 8'h81, 8);
      drain();
   endtask

   task automatic test_longest_channel();
      set_samples(12'd4095);
      send_event_words({SIGNATURE, 28'd1369}, 8'h10, 16);
      drain();
   endtask

   task automatic test_result_hold_off();
      set_samples(12'd12);
      hold_request = 1'b1;
      send_event_words({SIGNATURE, 28'(4 + 8 * 4)}, 8'hFF, 36);
      drain();
   endtask

   task automatic random_event();
      logic [MASK_W-1:0] mask;
      logic [3:0]        sig;
      int                chans;
      int                body;
      int                flavor;
      mask = 8'($urandom);
      if (mask == 0) begin
         mask = 8'h01 << $urandom_range(0, 7);
      end
      chans = count_channels(mask);
      body = 4 + chans * (samples_cfg / 3);
      flavor = $urandom_range(0, 99);
      steady = ($urandom_range(0, 4) == 0);
      if (flavor < 72) begin
         body = body + $urandom_range(0, chans - 1);
         send_event_words({SIGNATURE, 28'(body)}, mask, body);
      end else if (flavor < 82) begin
         send_event_words({SIGNATURE, 28'(body)}, mask, $urandom_range(1, body - 1));
      end else if (flavor < 88) begin
         send_event_words({SIGNATURE, 28'(body + chans * $urandom_range(1, 3))}, mask, 3);
      end else if (flavor < 91) begin
         send_event_words({SIGNATURE, 28'($urandom)}, mask, 2);
      end else if (flavor < 94) begin
         send_event_words({SIGNATURE, 28'(body)}, 8'h00, 3);
      end else if (flavor < 97) begin
         sig = 4'($urandom_range(0, 14));
         if (sig >= SIGNATURE) begin
            sig = sig + 4'd1;
         end
         send_event_words({sig, 28'($urandom)}, mask, $urandom_range(1, 3));
      end else begin
         repeat ($urandom_range(1, 4)) send_word($urandom, 1'b0);
      end
   endtask

   task automatic test_random_events();
      int goal;
      int events;
      for (int round = 1; round <= 5; round++) begin
         set_samples(12'(3 * round));
         goal = words_sent + 60;
         events = 0;
         while (words_sent < goal) begin
            random_event();
            events++;
            if (events % 10 == 0) begin
               drain();
            end
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_words();
      test_directed_events();
      test_odd_settings();
      test_longest_channel();
      test_result_hold_off();
      test_random_events();

      drain();
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
